>>> rtl/ppp_pkg.sv
`default_nettype none

package ppp_pkg;

  // coefficient store
  localparam int NUM_COEFS = 12;
  localparam int IDX_W     = 4;

  // internal width of points and coefficients after clamping
  localparam int VAL_W  = 32;
  localparam int DIM_W  = 15;

  // datapath widths
  localparam int PROD_W = 2 * VAL_W - 8;   // coef * pos, floored by 2^8
  localparam int CLIP_W = PROD_W + 1;      // sum of three products and offset
  localparam int MAG_W  = CLIP_W - 1;      // magnitude of a clip value
  localparam int M_W    = DIM_W + 15;      // viewport half extent in q.16
  localparam int SPLIT  = MAG_W / 2;       // magnitude split for the scale product
  localparam int PP_W   = SPLIT + M_W;     // one partial product
  localparam int N_W    = MAG_W + M_W;     // full dividend
  localparam int Q_W    = 41;              // quotient bits, clamp at 2^40
  localparam int SUM_W  = Q_W + 2;         // final screen sum

  // apb register map
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int ADDR_LSB = 2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_VP_WIDTH  = 1'b0,
    REG_VP_HEIGHT = 1'b1
  } reg_idx_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  // per-item flags and values that ride along with the divider
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        over_x;
    logic        over_y;
    logic        fault;
    logic [31:0] clip_w;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] den;
    div_lane_t        lx;
    div_lane_t        ly;
    side_t            side;
  } div_stage_t;

endpackage

`default_nettype wire

>>> rtl/perspective_point_projection_top.sv
`default_nettype none

// channel   direction  handshake            payload
// in_*      slave      in_tvalid/in_tready  command, coef index and value, point x y z
// out_*     master     out_tvalid/out_tready screen x, screen y, clip w, divide fault
// cfg_*     apb        psel/penable/pready  viewport width at 0x0, viewport height at 0x4
//
// one item per cycle when out_tready stays high
// a project command passes the front stages, the 41-stage restoring divider (one quotient bit
// per stage, x and y lanes) and the output buffer before it shows on out_tvalid
// a load writes the coefficient store at acceptance and gives no result
// synchronous reset clears the store to zero and loads 1920 x 1080
// a stall freezes the whole pipeline; a two-entry output buffer keeps in_tready registered

module perspective_point_projection_top #(
  parameter int  DATA_WIDTH = 32,
  localparam int InDataW    = ((ppp_pkg::IDX_W + 4 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [InDataW-1:0]           in_tdata,   // coef_index, coef_value, pos_x, pos_y, pos_z
  input  logic                         in_tuser,   // command
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [95:0]                  out_tdata,  // screen_x, screen_y, clip_w
  output logic                         out_tuser,  // div_fault
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ppp_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [ppp_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [ppp_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import ppp_pkg::*;

  localparam int ExtW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  typedef struct packed {
    logic        div_fault;
    logic [31:0] clip_w;
    logic [31:0] screen_y;
    logic [31:0] screen_x;
  } res_t;

  localparam logic [Q_W-1:0]   QLimit  = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] HalfPix = SUM_W'(32768);

  // sign-extend a field and clamp it to the internal width
  function automatic logic signed [VAL_W-1:0] clamp_in(input logic [DATA_WIDTH-1:0] raw);
    logic signed [ExtW-1:0] ext;
    logic [ExtW-VAL_W:0]    hi_bits;
    ext     = ExtW'($signed(raw));
    hi_bits = ext[ExtW-1:VAL_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      clamp_in = ext[VAL_W-1:0];
    end else if (ext[ExtW-1]) begin
      clamp_in = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      clamp_in = {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  // saturate a wide sum to signed 32 bits
  function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
    logic [SUM_W-32:0] hi_bits;
    hi_bits = v[SUM_W-1:31];
    if ((&hi_bits) || !(|hi_bits)) begin
      sat32 = v[31:0];
    end else if (v[SUM_W-1]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

  // quotient magnitude clamped to 2^40
  function automatic logic [Q_W-1:0] clamp_q(input logic over, input logic [Q_W-1:0] q);
    if (over || (q[Q_W-1] && (|q[Q_W-2:0]))) begin
      clamp_q = QLimit;
    end else begin
      clamp_q = q;
    end
  endfunction

  // configuration registers
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             cfg_wr;
  reg_idx_t         reg_sel;

  // input unpack
  cmd_t                    cmd;
  logic [IDX_W-1:0]        coef_index;
  logic signed [VAL_W-1:0] coef_value;
  logic signed [VAL_W-1:0] pos [3];
  logic                    en;
  logic                    acc;

  // coefficient store
  logic signed [VAL_W-1:0] coef_r [NUM_COEFS];

  // stage 1: products
  logic signed [2*VAL_W-1:0] prod_full   [3][3];
  logic signed [PROD_W-1:0]  s1_prod_nxt [3][3];
  logic signed [PROD_W-1:0]  s1_prod_r   [3][3];
  logic signed [VAL_W-1:0]   s1_off_r    [3];
  logic                      s1_valid_r;

  // stage 2: clip sums
  logic signed [CLIP_W-1:0] s2_clip_nxt [3];
  logic signed [CLIP_W-1:0] s2_clip_r   [3];
  logic                     s2_valid_r;

  // stage 3: magnitudes and flags
  logic [MAG_W-1:0] s3_mag_nxt [2];
  logic [MAG_W-1:0] s3_mag_r   [2];
  logic [MAG_W-1:0] s3_den_nxt;
  logic [MAG_W-1:0] s3_den_r;
  side_t            s3_side_nxt;
  side_t            s3_side_r;
  logic             s3_valid_r;

  // stage 4: scale partial products
  logic [M_W-1:0]   scale     [2];
  logic [PP_W-1:0]  s4_pp_nxt [2][2];
  logic [PP_W-1:0]  s4_pp_r   [2][2];
  logic [MAG_W-1:0] s4_den_r;
  side_t            s4_side_r;
  logic             s4_valid_r;

  // stage 5: dividends
  logic [N_W-1:0]   s5_n_nxt [2];
  logic [N_W-1:0]   s5_n_r   [2];
  logic [MAG_W-1:0] s5_den_r;
  side_t            s5_side_r;
  logic             s5_valid_r;

  // divider
  div_stage_t div_in;
  div_stage_t div_out;
  logic       div_valid;

  // final stage and output buffer
  logic [Q_W-1:0]   mag_x;
  logic [Q_W-1:0]   mag_y;
  logic [SUM_W-1:0] t_x;
  logic [SUM_W-1:0] t_y;
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  res_t             push_data;
  res_t             out_data_r;
  res_t             sp_data_r;
  logic             out_valid_r;
  logic             sp_valid_r;
  logic             push;
  logic             pop;

  // apb port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = reg_idx_t'(cfg_paddr[ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_VP_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_VP_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VP_WIDTH:  cfg_prdata = PDATA_W'(width_r);
      REG_VP_HEIGHT: cfg_prdata = PDATA_W'(height_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // input fields
  assign cmd        = cmd_t'(in_tuser);
  assign coef_index = in_tdata[IDX_W-1:0];
  assign coef_value = clamp_in(in_tdata[IDX_W +: DATA_WIDTH]);
  assign pos[0]     = clamp_in(in_tdata[IDX_W + DATA_WIDTH +: DATA_WIDTH]);
  assign pos[1]     = clamp_in(in_tdata[IDX_W + 2 * DATA_WIDTH +: DATA_WIDTH]);
  assign pos[2]     = clamp_in(in_tdata[IDX_W + 3 * DATA_WIDTH +: DATA_WIDTH]);

  // pipeline moves whenever the output buffer has a free entry
  assign en        = !sp_valid_r;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // coefficient load, out-of-range slots ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (acc && cmd == CMD_LOAD && coef_index < IDX_W'(NUM_COEFS)) begin
      coef_r[coef_index] <= coef_value;
    end
  end

  // stage 1: nine weight products, floored to q.32
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        prod_full[r][i]   = coef_r[r*4+i] * pos[i];
        s1_prod_nxt[r][i] = prod_full[r][i][2*VAL_W-1:8];
      end
    end
  end

  // stage 2: row sums with the offset scaled to q.32
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s2_clip_nxt[r] = CLIP_W'(s1_prod_r[r][0]) + CLIP_W'(s1_prod_r[r][1])
                     + CLIP_W'(s1_prod_r[r][2]) + CLIP_W'($signed({s1_off_r[r], 8'b0}));
    end
  end

  // stage 3: magnitudes, quotient signs, zero w and clip w output
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      s3_mag_nxt[r] = s2_clip_r[r][CLIP_W-1] ? MAG_W'(-s2_clip_r[r]) : MAG_W'(s2_clip_r[r]);
    end
    s3_den_nxt = s2_clip_r[2][CLIP_W-1] ? MAG_W'(-s2_clip_r[2]) : MAG_W'(s2_clip_r[2]);
    s3_side_nxt.neg_x  = s2_clip_r[0][CLIP_W-1] ^ s2_clip_r[2][CLIP_W-1];
    s3_side_nxt.neg_y  = s2_clip_r[1][CLIP_W-1] ^ s2_clip_r[2][CLIP_W-1];
    s3_side_nxt.over_x = 1'b0;
    s3_side_nxt.over_y = 1'b0;
    s3_side_nxt.fault  = (s2_clip_r[2] == '0);
    s3_side_nxt.clip_w = sat32(SUM_W'($signed(s2_clip_r[2][CLIP_W-1:16])));
  end

  // stage 4: magnitude times half extent, split in two halves
  assign scale[0] = {width_r, {(M_W-DIM_W){1'b0}}};
  assign scale[1] = {height_r, {(M_W-DIM_W){1'b0}}};

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      s4_pp_nxt[r][0] = PP_W'(s3_mag_r[r][SPLIT-1:0]) * PP_W'(scale[r]);
      s4_pp_nxt[r][1] = PP_W'(s3_mag_r[r][MAG_W-1:SPLIT]) * PP_W'(scale[r]);
    end
  end

  // stage 5: full dividends
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      s5_n_nxt[r] = N_W'(s4_pp_r[r][0]) + (N_W'(s4_pp_r[r][1]) << SPLIT);
    end
  end

  // front pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc && cmd == CMD_PROJECT;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s1_off_r[r] <= coef_r[r*4+3];
        s2_clip_r[r] <= s2_clip_nxt[r];
        for (int i = 0; i < 3; i++) begin
          s1_prod_r[r][i] <= s1_prod_nxt[r][i];
        end
      end
      for (int r = 0; r < 2; r++) begin
        s3_mag_r[r]    <= s3_mag_nxt[r];
        s4_pp_r[r][0]  <= s4_pp_nxt[r][0];
        s4_pp_r[r][1]  <= s4_pp_nxt[r][1];
        s5_n_r[r]      <= s5_n_nxt[r];
      end
      s3_den_r  <= s3_den_nxt;
      s3_side_r <= s3_side_nxt;
      s4_den_r  <= s3_den_r;
      s4_side_r <= s3_side_r;
      s5_den_r  <= s4_den_r;
      s5_side_r <= s4_side_r;
    end
  end

  // divider entry: upper dividend bits seed the remainder, quotient overflow test
  always_comb begin
    div_in.den         = s5_den_r;
    div_in.lx.rem      = MAG_W'(s5_n_r[0][N_W-1:Q_W]);
    div_in.lx.nlo      = s5_n_r[0][Q_W-1:0];
    div_in.lx.q        = '0;
    div_in.ly.rem      = MAG_W'(s5_n_r[1][N_W-1:Q_W]);
    div_in.ly.nlo      = s5_n_r[1][Q_W-1:0];
    div_in.ly.q        = '0;
    div_in.side        = s5_side_r;
    div_in.side.over_x = MAG_W'(s5_n_r[0][N_W-1:Q_W]) >= s5_den_r;
    div_in.side.over_y = MAG_W'(s5_n_r[1][N_W-1:Q_W]) >= s5_den_r;
  end

  ppp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s_valid (s5_valid_r),
    .s_in    (div_in),
    .m_valid (div_valid),
    .m_out   (div_out)
  );

  // viewport mapping and saturation
  always_comb begin
    mag_x = clamp_q(div_out.side.over_x, div_out.lx.q);
    mag_y = clamp_q(div_out.side.over_y, div_out.ly.q);
    t_x   = div_out.side.neg_x ? -SUM_W'(mag_x) : SUM_W'(mag_x);
    t_y   = div_out.side.neg_y ? -SUM_W'(mag_y) : SUM_W'(mag_y);
    sum_x = SUM_W'(scale[0]) + t_x + HalfPix;
    sum_y = SUM_W'(scale[1]) - t_y - HalfPix;
    if (div_out.side.fault) begin
      push_data.screen_x  = 32'h7FFF_FFFF;
      push_data.screen_y  = 32'h7FFF_FFFF;
      push_data.clip_w    = '0;
      push_data.div_fault = 1'b1;
    end else begin
      push_data.screen_x  = sat32(sum_x);
      push_data.screen_y  = sat32(sum_y);
      push_data.clip_w    = div_out.side.clip_w;
      push_data.div_fault = 1'b0;
    end
  end

  // two-entry output buffer: head drives the port, spare catches one in flight
  assign push = en && div_valid;
  assign pop  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sp_valid_r  <= 1'b0;
    end else if (pop) begin
      out_valid_r <= sp_valid_r || push;
      sp_valid_r  <= 1'b0;
    end else if (out_valid_r) begin
      sp_valid_r  <= sp_valid_r || push;
    end else begin
      out_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sp_valid_r) begin
        out_data_r <= sp_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (!out_valid_r) begin
      if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      sp_data_r <= push_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.clip_w, out_data_r.screen_y, out_data_r.screen_x};
  assign out_tuser  = out_data_r.div_fault;

  // spare entry only ever holds data behind a valid head
  a_spare_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    sp_valid_r |-> out_valid_r)
    else $error("output spare holds data with an empty head");

  // input side closes only after a result was held back downstream
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready dropped without an output stall");

  // a load never enters the arithmetic pipeline
  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && cmd == CMD_LOAD) |=> !s1_valid_r)
    else $error("load command entered the projection pipeline");

  // zero w gives saturated positions and a zero clip w
  a_fault_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[95:64] == 32'd0 && out_tdata[31:0] == 32'h7FFF_FFFF &&
       out_tdata[63:32] == 32'h7FFF_FFFF))
    else $error("fault result with unexpected payload");

endmodule

`default_nettype wire

>>> rtl/ppp_div.sv
`default_nettype none

module ppp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                s_valid,
  input  ppp_pkg::div_stage_t s_in,
  output logic                m_valid,
  output ppp_pkg::div_stage_t m_out
);
  import ppp_pkg::*;

  logic [Q_W-1:0] vld_r;
  div_stage_t     stg_r   [Q_W];
  div_stage_t     stg_nxt [Q_W];

  // one quotient bit: shift in the next dividend bit, subtract if it fits
  function automatic div_lane_t lane_step(input div_lane_t l, input logic [MAG_W-1:0] den);
    logic [MAG_W:0] shifted;
    logic [MAG_W:0] diff;
    div_lane_t      r;
    shifted = {l.rem, l.nlo[Q_W-1]};
    diff    = shifted - {1'b0, den};
    r.nlo   = {l.nlo[Q_W-2:0], 1'b0};
    if (shifted >= {1'b0, den}) begin
      r.rem = diff[MAG_W-1:0];
      r.q   = {l.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = shifted[MAG_W-1:0];
      r.q   = {l.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_stage_t stage_step(input div_stage_t s);
    div_stage_t r;
    r    = s;
    r.lx = lane_step(s.lx, s.den);
    r.ly = lane_step(s.ly, s.den);
    return r;
  endfunction

  // one step per stage, both lanes side by side
  always_comb begin
    stg_nxt[0] = stage_step(s_in);
    for (int k = 1; k < Q_W; k++) begin
      stg_nxt[k] = stage_step(stg_r[k-1]);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W-2:0], s_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign m_valid = vld_r[Q_W-1];
  assign m_out   = stg_r[Q_W-1];

endmodule

`default_nettype wire

>>> tb/tb_perspective_point_projection_top.sv
`timescale 1ns / 100ps

module tb_perspective_point_projection_top;
  import ppp_pkg::*;

  localparam int IN_W       = ((IDX_W + 4 * 32 + 7) / 8) * 8;
  localparam int PIPE_LAT   = 46;
  localparam int SETTLE     = PIPE_LAT + 8;
  localparam int IDLE_LIMIT = 5000;

  localparam logic [31:0]  COEF_ONE  = 32'h0100_0000;  // 1.0 in q8.24
  localparam logic [31:0]  POS_ONE   = 32'h0001_0000;  // 1.0 in q16.16
  localparam logic [31:0]  SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0]  SAT_NEG   = 32'h8000_0000;
  localparam longint       S32_MAX   = 64'sd2147483647;
  localparam longint       S32_MIN   = -64'sd2147483648;
  localparam logic [127:0] QUOT_CAP  = 128'd1 << 40;

  typedef struct {
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] coef;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_cmd_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] w;
    logic        fault;
  } pix_t;

  typedef struct {
    point_cmd_t item;
    bit         typed;
    pix_t       want;
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;   // coef_index, coef_value, pos_x, pos_y, pos_z
  logic              in_tuser    = 1'b0; // command
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [95:0]       out_tdata;          // screen_x, screen_y, clip_w
  logic              out_tuser;          // div_fault
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr  = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the block state
  logic signed [31:0] view_coef [NUM_COEFS];
  logic [DIM_W-1:0]   vp_width  = WIDTH_RST;
  logic [DIM_W-1:0]   vp_height = HEIGHT_RST;

  pix_t      pending_pix [$];
  stim_row_t directed_rows [$];
  int        err_count = 0;
  int        stall_pct = 0;
  int        hold_req  = 0;

  perspective_point_projection_top #(.DATA_WIDTH(32)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] sat32(longint v);
    if (v > S32_MAX) return SAT_POS;
    if (v < S32_MIN) return SAT_NEG;
    return v[31:0];
  endfunction

  // row dot product in q.32: products floored from q.40, offset scaled up
  function automatic longint row_dot(int row, longint px, longint py, longint pz);
    longint acc;
    acc = (longint'(view_coef[row*4]) * px) >>> 8;
    acc += (longint'(view_coef[row*4+1]) * py) >>> 8;
    acc += (longint'(view_coef[row*4+2]) * pz) >>> 8;
    acc += longint'(view_coef[row*4+3]) * 256;
    return acc;
  endfunction

  // trunc(num * m / den) with the magnitude clamped at 2^40
  function automatic longint scale_div(longint num, longint m, longint den);
    logic [63:0]  n_mag;
    logic [63:0]  d_mag;
    logic [127:0] quo;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    quo = ({64'd0, n_mag} * {64'd0, m}) / {64'd0, d_mag};
    if (quo > QUOT_CAP) quo = QUOT_CAP;
    return ((num < 0) != (den < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic pix_t project_point(point_cmd_t c);
    pix_t   r;
    longint cx, cy, cw, half_w, half_h;
    cx = row_dot(0, c.px, c.py, c.pz);
    cy = row_dot(1, c.px, c.py, c.pz);
    cw = row_dot(2, c.px, c.py, c.pz);
    // zero depth saturates both screen coordinates
    if (cw == 0) begin
      r = '{SAT_POS, SAT_POS, 32'h0, 1'b1};
      return r;
    end
    half_w = longint'(vp_width) << 15;
    half_h = longint'(vp_height) << 15;
    r.sx    = sat32(half_w + scale_div(cx, half_w, cw) + 32768);
    r.sy    = sat32(half_h - scale_div(cy, half_h, cw) - 32768);
    r.w     = sat32(cw >>> 16);
    r.fault = 1'b0;
    return r;
  endfunction

  // update the shadow store or queue the projected pixel
  task automatic apply_item(point_cmd_t c);
    if (c.cmd == CMD_PROJECT)
      pending_pix.push_back(project_point(c));
    else if (c.idx < NUM_COEFS)
      view_coef[c.idx] = c.coef;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
    err_count++;
  endtask

  task automatic check_result();
    pix_t want;
    if (pending_pix.size() == 0) begin
      report_mismatch("result with no projection pending", 32'h0, out_tdata[31:0]);
      return;
    end
    want = pending_pix.pop_front();
    if (out_tdata[31:0] !== want.sx)  report_mismatch("screen_x", want.sx, out_tdata[31:0]);
    if (out_tdata[63:32] !== want.sy) report_mismatch("screen_y", want.sy, out_tdata[63:32]);
    if (out_tdata[95:64] !== want.w)  report_mismatch("clip_w", want.w, out_tdata[95:64]);
    if (out_tuser !== want.fault)     report_mismatch("div_fault", 32'(want.fault), 32'(out_tuser));
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // result side back-pressure, with an occasional long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_perspective_point_projection_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // offer one command, returns at the edge where it is accepted
  task automatic send_cmd(point_cmd_t c, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= IN_W'({c.pz, c.py, c.px, c.coef, c.idx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_and_track(point_cmd_t c, int idle_pct);
    send_cmd(c, idle_pct);
    apply_item(c);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= PADDR_W'(r) << ADDR_LSB;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (r == REG_VP_WIDTH) vp_width = v[DIM_W-1:0];
    else vp_height = v[DIM_W-1:0];
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_pix.size() != 0);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] rand_word(bit for_coef);
    int unsigned span;
    span = for_coef ? 32'h0400_0000 : 32'h0100_0000;  // +-2.0 coefs, +-128 points
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      3:       return 32'h0;
      4:       return $urandom_range(0, 511) - 256;
      default: return $urandom_range(0, span) - span / 2;
    endcase
  endfunction

  task automatic random_items(int n_items, int idle_pct, bit drain_mid);
    point_cmd_t  c;
    int          sent;
    bit          paused;
    int unsigned roll;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      // sender pause until every pixel is back
      if (drain_mid && !paused && sent >= n_items / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait_drained();
      end
      c.cmd  = CMD_PROJECT;
      c.idx  = IDX_W'($urandom_range(0, NUM_COEFS - 1));
      c.coef = rand_word(1'b1);
      c.px   = rand_word(1'b0);
      c.py   = rand_word(1'b0);
      c.pz   = rand_word(1'b0);
      roll   = $urandom_range(0, 99);
      if (roll < 4) begin
        // clear the w row so depth goes to zero
        c.cmd  = CMD_LOAD;
        c.coef = '0;
        for (int j = 8; j < NUM_COEFS; j++) begin
          c.idx = IDX_W'(j);
          send_and_track(c, idle_pct);
        end
        sent += 4;
      end else if (roll < 20) begin
        c.cmd = CMD_LOAD;
        send_and_track(c, idle_pct);
        sent++;
      end else if (roll < 24) begin
        // load past the end of the store, ignored
        c.cmd = CMD_LOAD;
        c.idx = IDX_W'($urandom_range(NUM_COEFS, 15));
        send_and_track(c, idle_pct);
      end else begin
        send_and_track(c, idle_pct);
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [31:0] w, logic [31:0] h, int idle_pct, int rx_pct,
                           int n_items, int hold, bit drain_mid);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_VP_WIDTH, w);
    write_reg(REG_VP_HEIGHT, h);
    stall_pct = rx_pct;
    hold_req  = hold;
    random_items(n_items, idle_pct, drain_mid);
  endtask

  function automatic stim_row_t load_row(logic [IDX_W-1:0] idx, logic [31:0] v);
    stim_row_t r;
    r.item  = '{CMD_LOAD, idx, v, 32'h0, 32'h0, 32'h0};
    r.typed = 1'b0;
    r.want  = '{32'h0, 32'h0, 32'h0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t proj_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         bit zero_depth);
    stim_row_t r;
    r.item  = '{CMD_PROJECT, '0, 32'h0, x, y, z};
    r.typed = zero_depth;
    r.want  = '{SAT_POS, SAT_POS, 32'h0, 1'b1};
    return r;
  endfunction

  // ---------------------------------------------------------------- main

  initial begin
    for (int i = 0; i < NUM_COEFS; i++) view_coef[i] = '0;

    // directed table
    // empty store after reset gives zero depth
    directed_rows.push_back(proj_row(32'h0, 32'h0, 32'h0, 1'b1));
    directed_rows.push_back(proj_row(SAT_POS, SAT_NEG, SAT_POS, 1'b1));
    // simple view: x, y pass through, w from z
    directed_rows.push_back(load_row(0, COEF_ONE));
    directed_rows.push_back(load_row(5, COEF_ONE));
    directed_rows.push_back(load_row(10, COEF_ONE));
    directed_rows.push_back(proj_row(POS_ONE, -POS_ONE, 2 * POS_ONE, 1'b0));
    // loads past the end of the store change nothing
    directed_rows.push_back(load_row(12, SAT_POS));
    directed_rows.push_back(load_row(15, SAT_NEG));
    directed_rows.push_back(proj_row(POS_ONE / 2, POS_ONE / 4, POS_ONE, 1'b0));
    // z of zero gives zero depth
    directed_rows.push_back(proj_row(POS_ONE, 2 * POS_ONE, 32'h0, 1'b1));
    // tiny depth, quotient clamps
    directed_rows.push_back(proj_row(SAT_POS, SAT_NEG, 32'h1, 1'b0));
    // depth nonzero but floors to zero, then to minus one
    directed_rows.push_back(load_row(10, 32'h0));
    directed_rows.push_back(load_row(11, 32'h1));
    directed_rows.push_back(proj_row(POS_ONE, POS_ONE, 5 * POS_ONE, 1'b0));
    directed_rows.push_back(load_row(11, 32'hFFFF_FFFF));
    directed_rows.push_back(proj_row(-POS_ONE, POS_ONE, 32'h0, 1'b0));
    // coefficient extremes on row x, unit offset on w
    directed_rows.push_back(load_row(0, SAT_NEG));
    directed_rows.push_back(load_row(1, SAT_POS));
    directed_rows.push_back(load_row(2, SAT_NEG));
    directed_rows.push_back(load_row(3, SAT_POS));
    directed_rows.push_back(load_row(11, COEF_ONE));
    directed_rows.push_back(proj_row(SAT_NEG, SAT_POS, SAT_NEG, 1'b0));
    // w = x - y cancels to zero
    directed_rows.push_back(load_row(8, COEF_ONE));
    directed_rows.push_back(load_row(9, -COEF_ONE));
    directed_rows.push_back(load_row(11, 32'h0));
    directed_rows.push_back(proj_row(3 * POS_ONE, 3 * POS_ONE, 7 * POS_ONE, 1'b1));

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at the reset viewport
    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].item, 0);
      if (directed_rows[i].typed) pending_pix.push_back(directed_rows[i].want);
      else apply_item(directed_rows[i].item);
    end

    // random phases over viewport settings and flow control
    run_phase(640, 480, 0, 0, 180, 400, 1'b0);
    run_phase(1, 1, 66, 0, 180, 0, 1'b0);
    run_phase(16384, 16384, 0, 66, 180, 0, 1'b1);
    run_phase(0, 0, 28, 28, 160, 0, 1'b0);
    run_phase(32'h7FFF, 32'h7FFF, 0, 0, 150, 0, 1'b0);
    run_phase($urandom_range(1, 16384), $urandom_range(1, 16384), 28, 28, 200, 0, 1'b0);
    run_phase(1920, 1080, 66, 66, 60, 0, 1'b0);

    // drain and let the pipeline settle
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (err_count == 0)
      $display("tb_perspective_point_projection_top: PASS");
    else
      $display("tb_perspective_point_projection_top: FAIL");
    $finish;
  end

endmodule
